### rtl/aabb_ppt_pkg.sv
`timescale 1ns / 1ps

package aabb_ppt_pkg;

  // coordinate width; half-extents and the cutoff are one bit narrower
  localparam int CW   = 32;
  localparam int HW   = CW - 1;
  localparam int CUTW = CW - 1;
  // center difference and min/max bounds need one extra bit
  localparam int DW   = CW + 1;
  // clamped separation is at most 2^CW, so DW unsigned bits
  localparam int SEPW = DW;
  localparam int SQW  = 2 * SEPW;
  // sum of three squares
  localparam int SUMW = SQW + 2;
  localparam int CSQW = 2 * CUTW;
  localparam int NAX  = 3;

  // after the separation stages
  typedef struct packed {
    logic                      valid;
    logic                      overlap;
    logic                      contains;
    logic [NAX-1:0][SEPW-1:0]  sep;
  } sep_stage_t;

  // after the squaring stage
  typedef struct packed {
    logic                      valid;
    logic                      overlap;
    logic                      contains;
    logic [NAX-1:0][SQW-1:0]   sq;
    logic [CSQW-1:0]           cut_sq;
  } sq_stage_t;

  // final flags
  typedef struct packed {
    logic valid;
    logic in_cut;
    logic overlap;
    logic contains;
  } res_t;

endpackage

### rtl/aabb_ppt_front.sv
`timescale 1ns / 1ps

module aabb_ppt_front (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      in_valid,
  input  logic [aabb_ppt_pkg::NAX-1:0][aabb_ppt_pkg::CW-1:0]        ca,
  input  logic [aabb_ppt_pkg::NAX-1:0][aabb_ppt_pkg::HW-1:0]        ha,
  input  logic [aabb_ppt_pkg::NAX-1:0][aabb_ppt_pkg::CW-1:0]        cb,
  input  logic [aabb_ppt_pkg::NAX-1:0][aabb_ppt_pkg::HW-1:0]        hb,
  output aabb_ppt_pkg::sep_stage_t                                  sep_o
);

  localparam int DW  = aabb_ppt_pkg::DW;
  localparam int CW  = aabb_ppt_pkg::CW;
  localparam int NAX = aabb_ppt_pkg::NAX;

  // sign / zero extended operands
  logic [NAX-1:0][DW-1:0] ca_ext, cb_ext, ha_ext, hb_ext;

  // stage 1: differences, half-extent sums, box bounds
  logic                   s1_valid_r;
  logic [NAX-1:0][DW-1:0] dpos_nxt, dpos_r, dneg_nxt, dneg_r;
  logic [NAX-1:0][CW-1:0] hsum_nxt, hsum_r;
  logic [NAX-1:0][DW-1:0] amin_nxt, amin_r, bmin_nxt, bmin_r;
  logic [NAX-1:0][DW-1:0] amax_nxt, amax_r, bmax_nxt, bmax_r;

  // stage 2: separation and flags
  logic [NAX-1:0][DW:0]   diff;
  logic [NAX-1:0][DW-1:0] mag;
  logic [NAX-1:0]         pos;
  logic [NAX-1:0]         cont;
  aabb_ppt_pkg::sep_stage_t sep_nxt, sep_r;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      ca_ext[i]   = {ca[i][CW-1], ca[i]};
      cb_ext[i]   = {cb[i][CW-1], cb[i]};
      ha_ext[i]   = {2'b00, ha[i]};
      hb_ext[i]   = {2'b00, hb[i]};
      dpos_nxt[i] = ca_ext[i] - cb_ext[i];
      dneg_nxt[i] = cb_ext[i] - ca_ext[i];
      hsum_nxt[i] = {1'b0, ha[i]} + {1'b0, hb[i]};
      amin_nxt[i] = ca_ext[i] - ha_ext[i];
      bmin_nxt[i] = cb_ext[i] - hb_ext[i];
      amax_nxt[i] = ca_ext[i] + ha_ext[i];
      bmax_nxt[i] = cb_ext[i] + hb_ext[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dpos_r <= dpos_nxt;
    dneg_r <= dneg_nxt;
    hsum_r <= hsum_nxt;
    amin_r <= amin_nxt;
    bmin_r <= bmin_nxt;
    amax_r <= amax_nxt;
    bmax_r <= bmax_nxt;
  end

  // |ca - cb| - ha - hb, clamped at zero; containment per axis
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      mag[i]  = dpos_r[i][DW-1] ? dneg_r[i] : dpos_r[i];
      diff[i] = {1'b0, mag[i]} - {2'b00, hsum_r[i]};
      pos[i]  = !diff[i][DW] && (diff[i] != '0);
      cont[i] = ($signed(amin_r[i]) <= $signed(bmin_r[i])) &&
                ($signed(amax_r[i]) >  $signed(bmax_r[i]));
    end
    sep_nxt.valid    = s1_valid_r;
    sep_nxt.overlap  = ~|pos;
    sep_nxt.contains = &cont;
    for (int i = 0; i < NAX; i++) begin
      sep_nxt.sep[i] = pos[i] ? diff[i][DW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r.valid <= 1'b0;
    end else begin
      sep_r.valid <= sep_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    sep_r.overlap  <= sep_nxt.overlap;
    sep_r.contains <= sep_nxt.contains;
    sep_r.sep      <= sep_nxt.sep;
  end

  assign sep_o = sep_r;

endmodule

### rtl/aabb_ppt_square.sv
`timescale 1ns / 1ps

module aabb_ppt_square (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aabb_ppt_pkg::sep_stage_t          sep_i,
  input  logic [aabb_ppt_pkg::CUTW-1:0]     cutoff,
  output aabb_ppt_pkg::sq_stage_t           sq_o
);

  localparam int NAX = aabb_ppt_pkg::NAX;

  aabb_ppt_pkg::sq_stage_t sq_nxt, sq_r;

  // one multiplier per axis plus one for the squared cutoff
  always_comb begin
    sq_nxt.valid    = sep_i.valid;
    sq_nxt.overlap  = sep_i.overlap;
    sq_nxt.contains = sep_i.contains;
    for (int i = 0; i < NAX; i++) begin
      sq_nxt.sq[i] = sep_i.sep[i] * sep_i.sep[i];
    end
    sq_nxt.cut_sq   = cutoff * cutoff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.valid <= 1'b0;
    end else begin
      sq_r.valid <= sq_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_r.overlap  <= sq_nxt.overlap;
    sq_r.contains <= sq_nxt.contains;
    sq_r.sq       <= sq_nxt.sq;
    sq_r.cut_sq   <= sq_nxt.cut_sq;
  end

  assign sq_o = sq_r;

endmodule

### rtl/aabb_ppt_reduce.sv
`timescale 1ns / 1ps

module aabb_ppt_reduce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  aabb_ppt_pkg::sq_stage_t   sq_i,
  output aabb_ppt_pkg::res_t        res_o
);

  localparam int SUMW = aabb_ppt_pkg::SUMW;
  localparam int SQW  = aabb_ppt_pkg::SQW;
  localparam int CSQW = aabb_ppt_pkg::CSQW;

  // stage 4: sum of squares
  logic                    s4_valid_r;
  logic                    s4_overlap_r;
  logic                    s4_contains_r;
  logic [SUMW-1:0]         sum_nxt, sum_r;
  logic [CSQW-1:0]         cut_sq_r;

  // stage 5: compare and output
  aabb_ppt_pkg::res_t      res_nxt, res_r;

  always_comb begin
    sum_nxt = {{(SUMW-SQW){1'b0}}, sq_i.sq[0]} +
              {{(SUMW-SQW){1'b0}}, sq_i.sq[1]} +
              {{(SUMW-SQW){1'b0}}, sq_i.sq[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= sq_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_overlap_r  <= sq_i.overlap;
    s4_contains_r <= sq_i.contains;
    sum_r         <= sum_nxt;
    cut_sq_r      <= sq_i.cut_sq;
  end

  always_comb begin
    res_nxt.valid    = s4_valid_r;
    res_nxt.in_cut   = sum_r <= {{(SUMW-CSQW){1'b0}}, cut_sq_r};
    res_nxt.overlap  = s4_overlap_r;
    res_nxt.contains = s4_contains_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r.in_cut   <= res_nxt.in_cut;
    res_r.overlap  <= res_nxt.overlap;
    res_r.contains <= res_nxt.contains;
  end

  assign res_o = res_r;

endmodule

### rtl/aabb_pair_proximity_test_core.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   -------------------------------------------------
// in        start / busy         in_{a,b}_center_{x,y,z}, in_{a,b}_half_{x,y,z}
// out       out_valid (strobe)   out_within_cutoff, out_boxes_overlap,
//                                out_a_contains_b
// cfg       cfg_we               cfg_wdata (cutoff_distance)
//
// One request per cycle; busy is always low. Each result is driven on the
// out_ ports for one cycle, after its request has passed the five register
// stages: difference, separation, squaring, sum, compare. The receiver
// cannot stall; the pipeline never stops. Synchronous active-low reset
// clears the stage valid bits and sets the cutoff to zero.

module aabb_pair_proximity_test_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_a_center_x,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_a_center_y,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_a_center_z,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_a_half_x,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_a_half_y,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_a_half_z,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_b_center_x,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_b_center_y,
  input  logic [aabb_ppt_pkg::CW-1:0]         in_b_center_z,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_b_half_x,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_b_half_y,
  input  logic [aabb_ppt_pkg::HW-1:0]         in_b_half_z,
  output logic                                out_valid,
  output logic                                out_within_cutoff,
  output logic                                out_boxes_overlap,
  output logic                                out_a_contains_b,
  input  logic                                cfg_we,
  input  logic [aabb_ppt_pkg::CUTW-1:0]       cfg_wdata
);

  localparam int NAX = aabb_ppt_pkg::NAX;

  logic [aabb_ppt_pkg::CUTW-1:0]                 cutoff_r;
  logic                                          req;
  logic [NAX-1:0][aabb_ppt_pkg::CW-1:0]          ca, cb;
  logic [NAX-1:0][aabb_ppt_pkg::HW-1:0]          ha, hb;
  aabb_ppt_pkg::sep_stage_t                      sep_s;
  aabb_ppt_pkg::sq_stage_t                       sq_s;
  aabb_ppt_pkg::res_t                            res_s;

  // fully pipelined, always ready
  assign busy = 1'b0;
  assign req  = start && !busy;

  // cutoff register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
    end else if (cfg_we) begin
      cutoff_r <= cfg_wdata;
    end
  end

  // gather axes
  assign ca = {in_a_center_z, in_a_center_y, in_a_center_x};
  assign cb = {in_b_center_z, in_b_center_y, in_b_center_x};
  assign ha = {in_a_half_z, in_a_half_y, in_a_half_x};
  assign hb = {in_b_half_z, in_b_half_y, in_b_half_x};

  aabb_ppt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (req),
    .ca       (ca),
    .ha       (ha),
    .cb       (cb),
    .hb       (hb),
    .sep_o    (sep_s)
  );

  aabb_ppt_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .sep_i  (sep_s),
    .cutoff (cutoff_r),
    .sq_o   (sq_s)
  );

  aabb_ppt_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .sq_i  (sq_s),
    .res_o (res_s)
  );

  assign out_valid         = res_s.valid;
  assign out_within_cutoff = res_s.in_cut;
  assign out_boxes_overlap = res_s.overlap;
  assign out_a_contains_b  = res_s.contains;

  // every request gives a result
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req |-> ##5 out_valid)
    else $error("request produced no result");

  // no result without a request
  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req, 5))
    else $error("result without request");

  // overlapping boxes have zero gap, always within any cutoff
  a_overlap_within: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_boxes_overlap |-> out_within_cutoff)
    else $error("overlap without within_cutoff");

  // containment implies overlap
  a_contain_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_a_contains_b |-> out_boxes_overlap)
    else $error("containment without overlap");

endmodule

### dv/aabb_pair_proximity_test_core_tb.sv
`timescale 1ns / 1ps

module aabb_pair_proximity_test_core_tb;

  localparam int NAX  = aabb_ppt_pkg::NAX;
  localparam int CW   = aabb_ppt_pkg::CW;
  localparam int HW   = aabb_ppt_pkg::HW;
  localparam int CUTW = aabb_ppt_pkg::CUTW;

  // one box pair as driven on the in_ ports, axis 0..2 = x..z
  typedef struct packed {
    logic [NAX-1:0][CW-1:0] ac;
    logic [NAX-1:0][HW-1:0] ah;
    logic [NAX-1:0][CW-1:0] bc;
    logic [NAX-1:0][HW-1:0] bh;
  } box_pair_t;

  typedef struct packed {
    logic in_cut;
    logic overlap;
    logic contains;
  } flags_t;

  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [HW-1:0] HMAX = '1;
  localparam logic [CW-1:0] ONE  = CW'(65536);

  // expected flags per request, plus the cutoff currently in the block
  class pair_scoreboard;
    flags_t          pending_flags[$];
    logic [CUTW-1:0] cutoff;
    int unsigned     checked, errors, n_within, n_overlap, n_contains;

    function new();
      cutoff     = '0;
      checked    = 0;
      errors     = 0;
      n_within   = 0;
      n_overlap  = 0;
      n_contains = 0;
    endfunction

    // exact per-axis separation, clamped squares summed in 128 bits
    function flags_t predict(box_pair_t p);
      logic signed [63:0] ca, cb, ha, hb, d, sep;
      logic [127:0]       gap_sq, sep_w, cut_w;
      flags_t             f;
      gap_sq     = '0;
      f.overlap  = 1'b1;
      f.contains = 1'b1;
      for (int ax = 0; ax < NAX; ax++) begin
        ca = $signed(p.ac[ax]);
        cb = $signed(p.bc[ax]);
        ha = '0;
        hb = '0;
        ha[HW-1:0] = p.ah[ax];
        hb[HW-1:0] = p.bh[ax];
        d   = ca - cb;
        sep = ((d < 0) ? -d : d) - ha - hb;
        if (sep > 0) begin
          f.overlap = 1'b0;
          sep_w  = '0;
          sep_w[63:0] = sep;
          gap_sq = gap_sq + sep_w * sep_w;
        end
        if (ca - ha > cb - hb) f.contains = 1'b0;
        if (!(ca + ha > cb + hb)) f.contains = 1'b0;
      end
      cut_w = '0;
      cut_w[CUTW-1:0] = cutoff;
      f.in_cut = (gap_sq <= cut_w * cut_w);
      return f;
    endfunction

    function void note_request(box_pair_t p);
      pending_flags.push_back(predict(p));
    endfunction

    function void check_result(flags_t got);
      flags_t want;
      if (pending_flags.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("error: result %b with no request outstanding", got);
        return;
      end
      want = pending_flags.pop_front();
      checked++;
      n_within   += want.in_cut;
      n_overlap  += want.overlap;
      n_contains += want.contains;
      if (got.in_cut !== want.in_cut || got.overlap !== want.overlap ||
          got.contains !== want.contains) begin
        errors++;
        if (errors <= 10)
          $display("error: result %0d within exp %b got %b, overlap exp %b got %b, %s",
                   checked, want.in_cut, got.in_cut, want.overlap, got.overlap,
                   $sformatf("contains exp %b got %b", want.contains, got.contains));
      end
    endfunction

    function int pending();
      return pending_flags.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CUTW-1:0] cfg_wdata = '0;
  box_pair_t       pair = '0;
  logic            busy;
  logic            out_valid, out_within_cutoff, out_boxes_overlap, out_a_contains_b;

  pair_scoreboard  sb;
  bit              no_idle;
  int              n_settings;

  always #5 clk = ~clk;

  aabb_pair_proximity_test_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_a_center_x     (pair.ac[0]),
    .in_a_center_y     (pair.ac[1]),
    .in_a_center_z     (pair.ac[2]),
    .in_a_half_x       (pair.ah[0]),
    .in_a_half_y       (pair.ah[1]),
    .in_a_half_z       (pair.ah[2]),
    .in_b_center_x     (pair.bc[0]),
    .in_b_center_y     (pair.bc[1]),
    .in_b_center_z     (pair.bc[2]),
    .in_b_half_x       (pair.bh[0]),
    .in_b_half_y       (pair.bh[1]),
    .in_b_half_z       (pair.bh[2]),
    .out_valid         (out_valid),
    .out_within_cutoff (out_within_cutoff),
    .out_boxes_overlap (out_boxes_overlap),
    .out_a_contains_b  (out_a_contains_b),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // monitor: register writes, accepted requests, result strobes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.cutoff = cfg_wdata;
      if (start && !busy) sb.note_request(pair);
      if (out_valid)
        sb.check_result('{out_within_cutoff, out_boxes_overlap, out_a_contains_b});
    end
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic box_pair_t even_pair(logic [CW-1:0] ca, logic [HW-1:0] ha,
                                          logic [CW-1:0] cb, logic [HW-1:0] hb);
    box_pair_t p;
    for (int ax = 0; ax < NAX; ax++) begin
      p.ac[ax] = ca;
      p.ah[ax] = ha;
      p.bc[ax] = cb;
      p.bh[ax] = hb;
    end
    return p;
  endfunction

  function automatic box_pair_t junk_pair();
    box_pair_t p;
    for (int ax = 0; ax < NAX; ax++) begin
      p.ac[ax] = $urandom;
      p.ah[ax] = HW'($urandom);
      p.bc[ax] = $urandom;
      p.bh[ax] = HW'($urandom);
    end
    return p;
  endfunction

  // signed value in [-span, span]
  function automatic logic [CW-1:0] near_zero(int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] edge_center();
    case ($urandom_range(0, 3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HW-1:0] edge_half();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return HMAX;
      2:       return HW'($urandom_range(0, 16));
      default: return HW'($urandom);
    endcase
  endfunction

  // mix of shapes: wide random, near pairs, nested boxes, touching faces, extremes
  function automatic box_pair_t rand_pair();
    box_pair_t   p;
    int unsigned mode, mag, slack, ha, hb;
    int          d;
    logic [CW-1:0] c;
    p    = junk_pair();
    mode = $urandom_range(0, 9);
    for (int ax = 0; ax < NAX; ax++) begin
      case (mode)
        0, 1: ;
        2, 3, 4, 5: begin
          p.ac[ax] = near_zero(1 << 22);
          p.bc[ax] = near_zero(1 << 22);
          p.ah[ax] = HW'($urandom_range(0, 1 << 21));
          p.bh[ax] = HW'($urandom_range(0, 1 << 21));
        end
        6, 7: begin
          // B nested in A, one face sometimes flush
          c     = near_zero(1 << 28);
          ha    = $urandom_range(1, 1 << 24);
          mag   = $urandom_range(0, ha);
          slack = $urandom_range(0, 1) ? 0 : $urandom_range(0, ha - mag);
          hb    = ha - mag - slack;
          p.ac[ax] = c;
          p.ah[ax] = HW'(ha);
          p.bh[ax] = HW'(hb);
          p.bc[ax] = $urandom_range(0, 1) ? c + CW'(mag) : c - CW'(mag);
        end
        8: begin
          // faces touching, or one step apart either way
          ha = $urandom_range(0, 1 << 24);
          hb = $urandom_range(0, 1 << 24);
          d  = int'(ha + hb) + int'($urandom_range(0, 2)) - 1;
          p.ac[ax] = near_zero(1 << 28);
          p.ah[ax] = HW'(ha);
          p.bh[ax] = HW'(hb);
          p.bc[ax] = $urandom_range(0, 1) ? p.ac[ax] + CW'(d) : p.ac[ax] - CW'(d);
        end
        default: begin
          p.ac[ax] = edge_center();
          p.bc[ax] = edge_center();
          p.ah[ax] = edge_half();
          p.bh[ax] = edge_half();
        end
      endcase
    end
    return p;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // one request; returns in the step of the edge that took it
  task automatic send_pair(input box_pair_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      pair  <= junk_pair();
      repeat (gap) @(posedge clk);
    end
    pair  <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every outstanding request has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cutoff(input logic [CUTW-1:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    box_pair_t       p;
    logic [CUTW-1:0] phase_cut[6];
    sb         = new();
    n_settings = 0;
    no_idle    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, cutoff at its reset value of zero
    send_pair(even_pair('0, '0, '0, '0));
    send_pair(even_pair(CMIN, '0, CMAX, '0));
    send_pair(even_pair(CMAX, HMAX, CMIN, HMAX));
    send_pair(even_pair(CMAX, HMAX, CMAX, HMAX));
    send_pair(even_pair('0, HMAX, '0, '0));
    // touching faces, then one step apart, then touching on the other side
    send_pair(even_pair('0, HW'(10 * ONE), 20 * ONE, HW'(10 * ONE)));
    send_pair(even_pair('0, HW'(10 * ONE), 20 * ONE + 1, HW'(10 * ONE)));
    send_pair(even_pair('0, HW'(10 * ONE), -(20 * ONE), HW'(10 * ONE)));
    // nested with flush minimum, flush maximum, and the other way round
    send_pair(even_pair('0, HW'(100), -CW'(50), HW'(50)));
    send_pair(even_pair('0, HW'(100), CW'(50), HW'(50)));
    send_pair(even_pair(-CW'(50), HW'(50), '0, HW'(100)));
    p = even_pair('0, HW'(ONE), '0, HW'(ONE));
    p.bc[0] = 5 * ONE;
    send_pair(p);
    p = even_pair(CMIN, HMAX, CMIN, HMAX);
    p.bc[2] = CMAX;
    send_pair(p);

    // cutoff boundary: one axis and a 3-4-5 diagonal
    write_cutoff(CUTW'(5 * ONE));
    p = even_pair('0, '0, '0, '0);
    p.bc[1] = 5 * ONE;
    send_pair(p);
    p.bc[1] = 5 * ONE + 1;
    send_pair(p);
    p = even_pair('0, '0, '0, '0);
    p.bc[0] = 3 * ONE;
    p.bc[2] = -(4 * ONE);
    send_pair(p);
    p.bc[2] = -(4 * ONE) - 1;
    send_pair(p);

    // largest cutoff against the largest gaps
    write_cutoff('1);
    send_pair(even_pair(CMIN, '0, CMAX, '0));
    p = even_pair('0, '0, '0, '0);
    p.bc[0] = CMAX;
    send_pair(p);
    p.ac[0] = '1;
    send_pair(p);
    send_pair(even_pair(CMAX, '0, CMIN, '0));

    // random phases, each under its own cutoff
    phase_cut[0] = CUTW'($urandom_range(0, 1 << 23));
    phase_cut[1] = '0;
    phase_cut[2] = CUTW'($urandom);
    phase_cut[3] = '1;
    phase_cut[4] = CUTW'(5 * ONE);
    phase_cut[5] = CUTW'($urandom_range(0, 1 << 23));
    for (int ph = 0; ph < 6; ph++) begin
      write_cutoff(phase_cut[ph]);
      no_idle = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 64; i++) begin
        if ($urandom_range(0, 49) == 0) drain();
        send_pair(rand_pair());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("summary: %0d box pairs checked under %0d cutoff settings", sb.checked,
             n_settings + 1);
    $display("summary: %0d overlapping, %0d within cutoff, %0d with A containing B",
             sb.n_overlap, sb.n_within, sb.n_contains);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/aabb_ppt_pkg.sv
rtl/aabb_ppt_front.sv
rtl/aabb_ppt_square.sv
rtl/aabb_ppt_reduce.sv
rtl/aabb_pair_proximity_test_core.sv
dv/aabb_pair_proximity_test_core_tb.sv
